FILE: design/bedf_pkg.sv
`timescale 1ns / 1ps

package bedf_pkg;

  // Field widths
  localparam int PIX_W   = 8;
  localparam int NPIX    = 10;
  localparam int STEP_W  = 6;
  localparam int THR_W   = 4;
  localparam int ACT_W   = 12;
  localparam int IN_W    = PIX_W * NPIX;
  localparam int OUT_W   = PIX_W * 4;
  localparam int MODE_W  = 2;

  localparam logic [STEP_W-1:0] STEP_RESET = 6'd8;
  localparam int                THR_BIAS   = 10;
  localparam int                FLAT_MIN   = 6;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE   = 2'd0,
    MODE_WEAK   = 2'd1,
    MODE_STRONG = 2'd2
  } mode_t;

  // Neighbor difference within +/- thr
  function automatic logic flat_diff(input logic [PIX_W-1:0] a,
                                     input logic [PIX_W-1:0] b,
                                     input logic [THR_W-1:0] thr);
    logic signed [PIX_W+1:0] d;
    logic signed [PIX_W+1:0] t;
    d = $signed({2'b00, a}) - $signed({2'b00, b});
    t = $signed({{(PIX_W+2-THR_W){1'b0}}, thr});
    return (d >= -t) && (d <= t);
  endfunction

endpackage

FILE: design/bedf_act.sv
`timescale 1ns / 1ps

// Edge activity term before the divide by 8: 2*(a-b) - 5*(c-d) + 4
module bedf_act
  import bedf_pkg::*;
(
  input  logic [PIX_W-1:0]        a,
  input  logic [PIX_W-1:0]        b,
  input  logic [PIX_W-1:0]        c,
  input  logic [PIX_W-1:0]        d,
  output logic signed [ACT_W-1:0] act
);

  logic signed [ACT_W-1:0] dab;
  logic signed [ACT_W-1:0] dcd;

  assign dab = $signed({{(ACT_W-PIX_W){1'b0}}, a}) - $signed({{(ACT_W-PIX_W){1'b0}}, b});
  assign dcd = $signed({{(ACT_W-PIX_W){1'b0}}, c}) - $signed({{(ACT_W-PIX_W){1'b0}}, d});

  // 5*x as 4*x + x
  assign act = (dab <<< 1) - ((dcd <<< 2) + dcd) + ACT_W'(4);

endmodule

FILE: design/block_edge_deblocking_filter_unit.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake                 Payload
// in_       in   in_tvalid / in_tready     in_tdata: pix0..pix9, 8 bits each
// out_      out  out_tvalid / out_tready   out_tdata: out3..out6, out_tuser: mode_taken
// cfg_      in   cfg_valid / cfg_ready     cfg_data: step_size
//
// Three register stages: flatness and activity terms, decisions, correction.
// One line per cycle while out_tready is high; out_tvalid follows the input transfer through the three register stages.
// Each stage holds while the stage after it is full and stalled; bubbles collapse,
// so input stalls only when all three stages are full and out_tready is low.
// rst_n (synchronous) empties the pipeline and sets step_size to 8.
// cfg_ready is always high; step_size is written whenever cfg_valid is high.
module block_edge_deblocking_filter_unit
  import bedf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,   // pix0 .. pix9 from bit 0 up
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,  // out3, out4, out5, out6 from bit 0 up
  output logic [MODE_W-1:0] out_tuser,  // mode_taken
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [STEP_W-1:0] cfg_data    // step_size
);

  logic [STEP_W-1:0] step_r;
  logic [PIX_W-1:0]  p [NPIX];
  logic [THR_W-1:0]  thr;
  logic [STEP_W:0]   thr_sum;

  // Pipeline control
  logic v1_r, v2_r, out_valid_r;
  logic rdy1, rdy2, rdy3;

  assign rdy3      = !out_valid_r || out_tready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_RESET;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        step_r <= cfg_data;
      end
      if (rdy1) begin
        v1_r <= in_tvalid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        out_valid_r <= v2_r;
      end
    end
  end

  // ---------------- Stage 1: flatness, activity terms, smoothing sums
  for (genvar i = 0; i < NPIX; i++) begin : g_pix
    assign p[i] = in_tdata[i*PIX_W +: PIX_W];
  end

  assign thr_sum = {1'b0, step_r} + (STEP_W+1)'(THR_BIAS);
  assign thr     = thr_sum[STEP_W:3];

  logic [8:0]              flat_nxt;
  logic signed [ACT_W-1:0] x30_nxt, x31_nxt, x32_nxt;
  logic signed [PIX_W:0]   d45_nxt;
  logic [PIX_W-1:0]        mn_nxt [4];
  logic [PIX_W-1:0]        mx_nxt [4];
  logic [10:0]             e2, e3, e4, e5, e6, e7, s27;
  logic [10:0]             t3, t4, t5, t6;

  assign flat_nxt[0] = flat_diff(p[1], p[2], thr);
  assign flat_nxt[1] = flat_diff(p[2], p[3], thr);
  assign flat_nxt[2] = flat_diff(p[3], p[4], thr);
  assign flat_nxt[3] = flat_diff(p[4], p[5], thr);
  assign flat_nxt[4] = flat_diff(p[0], p[1], thr);
  assign flat_nxt[5] = flat_diff(p[5], p[6], thr);
  assign flat_nxt[6] = flat_diff(p[6], p[7], thr);
  assign flat_nxt[7] = flat_diff(p[7], p[8], thr);
  assign flat_nxt[8] = flat_diff(p[8], p[9], thr);

  bedf_act u_act30 (.a(p[3]), .b(p[6]), .c(p[4]), .d(p[5]), .act(x30_nxt));
  bedf_act u_act31 (.a(p[1]), .b(p[4]), .c(p[2]), .d(p[3]), .act(x31_nxt));
  bedf_act u_act32 (.a(p[5]), .b(p[8]), .c(p[6]), .d(p[7]), .act(x32_nxt));

  assign d45_nxt = $signed({1'b0, p[4]}) - $signed({1'b0, p[5]});

  // First level of the min/max tree over pix1..pix8
  for (genvar k = 0; k < 4; k++) begin : g_pair
    assign mn_nxt[k] = (p[2*k+1] < p[2*k+2]) ? p[2*k+1] : p[2*k+2];
    assign mx_nxt[k] = (p[2*k+1] < p[2*k+2]) ? p[2*k+2] : p[2*k+1];
  end

  // Strong smoothing candidates
  assign e2  = 11'(p[2]);
  assign e3  = 11'(p[3]);
  assign e4  = 11'(p[4]);
  assign e5  = 11'(p[5]);
  assign e6  = 11'(p[6]);
  assign e7  = 11'(p[7]);
  assign s27 = e2 + e7;
  assign t3  = ((e2 + e3) << 1) + (e2 + e3) + s27 + 11'd4;
  assign t6  = ((e7 + e6) << 1) + (e7 + e6) + s27 + 11'd4;
  assign t4  = e2 + (e4 << 1) + e4 + (s27 << 1) + 11'd4;
  assign t5  = e7 + (e5 << 1) + e5 + (s27 << 1) + 11'd4;

  logic [8:0]              s1_flat_r;
  logic signed [ACT_W-1:0] s1_x30_r, s1_x31_r, s1_x32_r;
  logic signed [PIX_W:0]   s1_d45_r;
  logic [PIX_W-1:0]        s1_mn_r [4];
  logic [PIX_W-1:0]        s1_mx_r [4];
  logic [PIX_W-1:0]        s1_st_r [4];
  logic [PIX_W-1:0]        s1_pix_r [4];

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_flat_r   <= flat_nxt;
      s1_x30_r    <= x30_nxt;
      s1_x31_r    <= x31_nxt;
      s1_x32_r    <= x32_nxt;
      s1_d45_r    <= d45_nxt;
      s1_mn_r     <= mn_nxt;
      s1_mx_r     <= mx_nxt;
      s1_st_r[0]  <= t3[10:3];
      s1_st_r[1]  <= t4[10:3];
      s1_st_r[2]  <= t5[10:3];
      s1_st_r[3]  <= t6[10:3];
      s1_pix_r[0] <= p[3];
      s1_pix_r[1] <= p[4];
      s1_pix_r[2] <= p[5];
      s1_pix_r[3] <= p[6];
    end
  end

  // ---------------- Stage 2: mode decisions
  logic [3:0]            flat_cnt;
  logic [PIX_W-1:0]      mn01, mn23, mn_all, mx01, mx23, mx_all, rng;
  logic                  strong_nxt;
  logic signed [PIX_W:0] a30, a31, a32, a30_neg, a31_neg, a32_neg;
  logic [PIX_W-1:0]      m30, m31, m32, mo;
  logic signed [PIX_W:0] diff;
  logic                  weak_nxt;
  logic signed [PIX_W:0] d45_abs;

  assign flat_cnt = 4'($countones(s1_flat_r));
  assign mn01     = (s1_mn_r[0] < s1_mn_r[1]) ? s1_mn_r[0] : s1_mn_r[1];
  assign mn23     = (s1_mn_r[2] < s1_mn_r[3]) ? s1_mn_r[2] : s1_mn_r[3];
  assign mn_all   = (mn01 < mn23) ? mn01 : mn23;
  assign mx01     = (s1_mx_r[0] > s1_mx_r[1]) ? s1_mx_r[0] : s1_mx_r[1];
  assign mx23     = (s1_mx_r[2] > s1_mx_r[3]) ? s1_mx_r[2] : s1_mx_r[3];
  assign mx_all   = (mx01 > mx23) ? mx01 : mx23;
  assign rng      = mx_all - mn_all;

  // Strong mode: flat count of six or more and pixel range below twice step_size
  assign strong_nxt = (flat_cnt >= 4'(FLAT_MIN)) && ({1'b0, rng} < {2'b00, step_r, 1'b0});

  // Divide by 8 rounding toward minus infinity
  assign a30     = s1_x30_r[ACT_W-1:3];
  assign a31     = s1_x31_r[ACT_W-1:3];
  assign a32     = s1_x32_r[ACT_W-1:3];
  assign a30_neg = -a30;
  assign a31_neg = -a31;
  assign a32_neg = -a32;
  assign m30     = a30[PIX_W] ? a30_neg[PIX_W-1:0] : a30[PIX_W-1:0];
  assign m31     = a31[PIX_W] ? a31_neg[PIX_W-1:0] : a31[PIX_W-1:0];
  assign m32     = a32[PIX_W] ? a32_neg[PIX_W-1:0] : a32[PIX_W-1:0];
  assign mo      = (m31 < m32) ? m31 : m32;
  assign diff    = $signed({1'b0, m30}) - $signed({1'b0, mo});

  assign weak_nxt = (m30 < {2'b00, step_r}) && (diff > 0)
                    && (s1_d45_r[PIX_W] != a30[PIX_W]);

  assign d45_abs = s1_d45_r[PIX_W] ? -s1_d45_r : s1_d45_r;

  logic             s2_strong_r, s2_weak_r, s2_neg_r;
  logic [PIX_W-1:0] s2_diff_r;
  logic [PIX_W-2:0] s2_lim_r;
  logic [PIX_W-1:0] s2_st_r [4];
  logic [PIX_W-1:0] s2_pix_r [4];

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_strong_r <= strong_nxt;
      s2_weak_r   <= weak_nxt;
      s2_neg_r    <= s1_d45_r[PIX_W];
      s2_diff_r   <= diff[PIX_W-1:0];
      s2_lim_r    <= d45_abs[PIX_W-1:1];
      s2_st_r     <= s1_st_r;
      s2_pix_r    <= s1_pix_r;
    end
  end

  // ---------------- Stage 3: weak correction and output select
  logic [PIX_W+2:0] m5x;
  logic [PIX_W-1:0] m5, mc, r4, r5;
  logic [OUT_W-1:0] tdata_nxt;
  mode_t            mode_nxt;

  assign m5x = ({3'b000, s2_diff_r} << 2) + {3'b000, s2_diff_r};
  assign m5  = m5x[PIX_W+2:3];
  assign mc  = (m5 > {1'b0, s2_lim_r}) ? {1'b0, s2_lim_r} : m5;
  assign r4  = s2_neg_r ? (s2_pix_r[1] + mc) : (s2_pix_r[1] - mc);
  assign r5  = s2_neg_r ? (s2_pix_r[2] - mc) : (s2_pix_r[2] + mc);

  always_comb begin
    if (s2_strong_r) begin
      tdata_nxt = {s2_st_r[3], s2_st_r[2], s2_st_r[1], s2_st_r[0]};
      mode_nxt  = MODE_STRONG;
    end else if (s2_weak_r) begin
      tdata_nxt = {s2_pix_r[3], r5, r4, s2_pix_r[0]};
      mode_nxt  = MODE_WEAK;
    end else begin
      tdata_nxt = {s2_pix_r[3], s2_pix_r[2], s2_pix_r[1], s2_pix_r[0]};
      mode_nxt  = MODE_NONE;
    end
  end

  logic [OUT_W-1:0] out_data_r;
  mode_t            out_mode_r;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      out_data_r <= tdata_nxt;
      out_mode_r <= mode_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_mode_r;

endmodule

FILE: design/bedf_checker.sv
`timescale 1ns / 1ps

module bedf_checker
  import bedf_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_W-1:0]  out_tdata,
  input logic [MODE_W-1:0] out_tuser,
  input logic              cfg_ready
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  // Input backpressure only when all stages are full and the output is stalled
  a_bp_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled with room in the pipeline");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

  // A newly raised out_tvalid needs a matching earlier input transfer
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    (!$past(out_tvalid) && out_tvalid) |-> $past(in_tvalid && in_tready, 3))
    else $error("result without a matching input transfer");

  // Configuration never waits
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("cfg_ready low");

endmodule

bind block_edge_deblocking_filter_unit bedf_checker u_bedf_checker (.*);
